/* rtl/pcbsa_pkg.sv */
// shared types, constants and helpers for the per-class bitmap slot allocator
package pcbsa_pkg;

  localparam int unsigned ClassCount = 8;
  localparam int unsigned SlotsMax   = 64;
  localparam int unsigned MapWidth   = 64;
  localparam int unsigned ClassIdxW  = (ClassCount > 1) ? $clog2(ClassCount) : 1;
  localparam int unsigned ClassIdW   = 4;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned CountW     = 7;
  localparam int unsigned CfgAddrW   = 4;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 144;

  typedef enum logic [1:0] {
    OP_PUT        = 2'd0,
    OP_TAKE       = 2'd1,
    OP_FREE_ALLOC = 2'd2
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } pcbsa_cmd_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [SlotW-1:0] lowest_set(input logic [MapWidth-1:0] v);
    logic [SlotW-1:0] idx;
    idx = '0;
    for (int i = MapWidth - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SlotW'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/pcbsa_ctrl.sv */
// controller: input capture, execute step and output register valid
module pcbsa_ctrl import pcbsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pcbsa_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the result register is free or being drained
        if (can_load) begin
          cmd_o.execute = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/pcbsa_datapath.sv */
// datapath: class bitmaps, slot counts, find-first-free and result register
module pcbsa_datapath import pcbsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcbsa_cmd_t            cmd_i,
  input  logic [1:0]            op_i,
  input  logic [ClassIdW-1:0]   size_cls_i,
  input  logic [SlotW-1:0]      slot_i,
  input  logic                  cfg_we_i,
  input  logic [CfgAddrW-1:0]   cfg_addr_i,
  input  logic [CountW-1:0]     cfg_wdata_i,
  output logic                  ok_o,
  output logic [SlotW-1:0]      taken_slot_o,
  output logic [MapWidth-1:0]   free_map_o,
  output logic [MapWidth-1:0]   alloc_map_o,
  output logic [ClassCount-1:0] touched_mask_o
);

  logic [1:0]            op_q;
  logic [ClassIdW-1:0]   cls_q;
  logic [SlotW-1:0]      slot_q;

  logic [CountW-1:0]     count_q [ClassCount];
  logic [MapWidth-1:0]   free_q  [ClassCount];
  logic [MapWidth-1:0]   alloc_q [ClassCount];
  logic [ClassCount-1:0] touched_q, touched_d;

  logic                  ok_q;
  logic [SlotW-1:0]      taken_q;
  logic [MapWidth-1:0]   free_out_q, alloc_out_q;
  logic [ClassCount-1:0] touched_out_q;

  logic [ClassIdxW-1:0]  idx;
  logic                  cls_ok, slot_ok, ok;
  logic [MapWidth-1:0]   cur_free, cur_alloc, new_free, new_alloc, sel_bit, take_bit;
  logic [SlotW-1:0]      low_slot, taken;

  assign idx       = cls_q[ClassIdxW-1:0];
  assign cls_ok    = ({1'b0, cls_q} < (ClassIdW + 1)'(ClassCount));
  assign cur_free  = cls_ok ? free_q[idx]  : '0;
  assign cur_alloc = cls_ok ? alloc_q[idx] : '0;
  assign slot_ok   = cls_ok && ({1'b0, slot_q} < count_q[idx]);
  assign sel_bit   = MapWidth'(1) << slot_q;
  assign low_slot  = lowest_set(cur_free);
  assign take_bit  = MapWidth'(1) << low_slot;

  always_comb begin
    new_free  = cur_free;
    new_alloc = cur_alloc;
    touched_d = touched_q;
    ok        = 1'b0;
    taken     = '0;
    unique case (op_e'(op_q))
      OP_PUT: begin
        if (slot_ok && ((cur_free | cur_alloc) & sel_bit) == '0) begin
          new_free  = cur_free | sel_bit;
          touched_d = touched_q | (ClassCount'(1) << idx);
          ok        = 1'b1;
        end
      end
      OP_TAKE: begin
        if (cls_ok && cur_free != '0) begin
          new_free  = cur_free & ~take_bit;
          new_alloc = cur_alloc | take_bit;
          taken     = low_slot;
          ok        = 1'b1;
        end
      end
      OP_FREE_ALLOC: begin
        if (slot_ok && (cur_alloc & sel_bit) != '0 && (cur_free & sel_bit) == '0) begin
          new_alloc = cur_alloc & ~sel_bit;
          new_free  = cur_free | sel_bit;
          ok        = 1'b1;
        end
      end
      default: begin
        // unused operation code: rejected, maps still reported
        ok = 1'b0;
      end
    endcase
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      cls_q  <= size_cls_i;
      slot_q <= slot_i;
    end
  end

  // per-class state and slot counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ClassCount; i++) begin
        count_q[i] <= CountW'(SlotsMax);
        free_q[i]  <= '0;
        alloc_q[i] <= '0;
      end
      touched_q <= '0;
    end else begin
      if (cfg_we_i && ({1'b0, cfg_addr_i} < (CfgAddrW + 1)'(ClassCount))) begin
        count_q[cfg_addr_i[ClassIdxW-1:0]] <= cfg_wdata_i;
      end
      if (cmd_i.execute && cls_ok) begin
        free_q[idx]  <= new_free;
        alloc_q[idx] <= new_alloc;
        touched_q    <= touched_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      ok_q          <= ok;
      taken_q       <= taken;
      free_out_q    <= new_free;
      alloc_out_q   <= new_alloc;
      touched_out_q <= touched_d;
    end
  end

  assign ok_o           = ok_q;
  assign taken_slot_o   = taken_q;
  assign free_map_o     = free_out_q;
  assign alloc_map_o    = alloc_out_q;
  assign touched_mask_o = touched_out_q;

endmodule

/* rtl/per_class_bitmap_slot_allocator.sv */
// top level of the per-class bitmap slot allocator
// Each request has a capture step for the transfer and an execute step where the
// class's free and allocated bitmaps are read, the 64-bit find-first-free encoder
// and the map update run, and the result register is loaded. A new request is
// accepted in the cycle after the execute step even while the previous result is
// still waiting; the execute step holds only when the result register is full and
// not being drained. The user must write slot counts over the cfg port only while
// idle, which the block does not enforce. Writes to indexes at or above the class
// count are ignored and a count above 64 acts as 64. Maps and touched mask reset.
module per_class_bitmap_slot_allocator import pcbsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // operation[1:0], size_cls[5:2], slot[11:6], zero pad [15:12]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // ok[0], taken_slot[6:1], free_map[70:7], alloc_map[134:71],
  // touched_mask[142:135], zero pad [143]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CountW-1:0]   cfg_wdata_i
);

  pcbsa_cmd_t            cmd;
  logic                  ok;
  logic [SlotW-1:0]      taken_slot;
  logic [MapWidth-1:0]   free_map, alloc_map;
  logic [ClassCount-1:0] touched_mask;

  pcbsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  pcbsa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (s_axis_tdata[1:0]),
    .size_cls_i     (s_axis_tdata[5:2]),
    .slot_i         (s_axis_tdata[11:6]),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ok_o           (ok),
    .taken_slot_o   (taken_slot),
    .free_map_o     (free_map),
    .alloc_map_o    (alloc_map),
    .touched_mask_o (touched_mask)
  );

  assign m_axis_tdata = {1'b0, touched_mask, alloc_map, free_map, taken_slot, ok};

endmodule

/* rtl/pcbsa_checker.sv */
// port-level checks for the per-class bitmap slot allocator
module pcbsa_checker import pcbsa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                cfg_we_i,
  input logic [CfgAddrW-1:0] cfg_addr_i,
  input logic [CountW-1:0]   cfg_wdata_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight: no second transfer right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a transfer");

  // a slot is never both free and allocated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[70:7] & m_axis_tdata[134:71]) == '0)
    else $error("slot reported free and allocated");

  // rejected requests report no taken slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == '0)
    else $error("taken slot on a rejected request");

  // a successful take leaves the taken slot allocated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[6:1] != '0
      |-> m_axis_tdata[71 + m_axis_tdata[6:1]])
    else $error("taken slot not marked allocated");

endmodule

bind per_class_bitmap_slot_allocator pcbsa_checker u_pcbsa_checker (.*);

/* tb/tb_per_class_bitmap_slot_allocator.sv */
// testbench for the per-class bitmap slot allocator with a request predictor
module tb_per_class_bitmap_slot_allocator;
  import pcbsa_pkg::*;

  localparam logic [1:0] OpUndefined = 2'd3;
  localparam int RxAlways   = 0;
  localparam int RxRandom   = 1;
  localparam int RxPattern  = 2;
  localparam int RxSparse   = 3;
  localparam int CycleLimit = 200000;
  localparam int LongHold   = 400;
  localparam int PhaseItems = 240;
  localparam int PhaseCount = 8;

  // fields from the lowest bit up: op, cls, slot
  typedef struct packed {
    logic [SlotW-1:0]    slot;
    logic [ClassIdW-1:0] cls;
    logic [1:0]          op;
  } alloc_req_t;

  // fields from the lowest bit up: ok, taken, free_map, alloc_map, touched
  typedef struct packed {
    logic [ClassCount-1:0] touched;
    logic [MapWidth-1:0]   alloc_map;
    logic [MapWidth-1:0]   free_map;
    logic [SlotW-1:0]      taken;
    logic                  ok;
  } alloc_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // operation[1:0], size_cls[5:2], slot[11:6], zero pad [15:12]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // ok[0], taken_slot[6:1], free_map[70:7], alloc_map[134:71],
  // touched_mask[142:135], zero pad [143]
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CountW-1:0]   cfg_wdata_i = '0;

  // predictor state
  logic [MapWidth-1:0]   free_maps [ClassCount];
  logic [MapWidth-1:0]   alloc_maps [ClassCount];
  logic [ClassCount-1:0] touched_classes;
  logic [CountW-1:0]     slot_counts [ClassCount];

  alloc_req_t pending_reqs [$];
  alloc_rsp_t expected_rsps [$];
  int         outstanding = 0;
  int         err_count = 0;
  int         cycle_count = 0;

  bit         gaps_on = 1'b0;
  int         rx_mode = RxAlways;
  bit         hold_req = 1'b0;

  per_class_bitmap_slot_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic alloc_rsp_t allocate_step(input alloc_req_t rq);
    alloc_rsp_t           rsp;
    logic [MapWidth-1:0]  mask;
    logic [ClassIdxW-1:0] c;
    logic                 cls_ok;
    logic                 slot_ok;
    logic                 found;
    rsp = '0;
    c = rq.cls[ClassIdxW-1:0];
    cls_ok = rq.cls < ClassCount;
    // counts above the map width compare as if they were the full width
    slot_ok = cls_ok && ({1'b0, rq.slot} < slot_counts[c]);
    mask = MapWidth'(1) << rq.slot;
    found = 1'b0;
    case (rq.op)
      OP_PUT: begin
        if (slot_ok && ((free_maps[c] | alloc_maps[c]) & mask) == '0) begin
          free_maps[c] |= mask;
          touched_classes[c] = 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_TAKE: begin
        // the slot count is not consulted here
        if (cls_ok) begin
          for (int i = 0; i < MapWidth; i++) begin
            if (!found && free_maps[c][i]) begin
              found = 1'b1;
              rsp.taken = SlotW'(i);
            end
          end
          if (found) begin
            mask = MapWidth'(1) << rsp.taken;
            free_maps[c] &= ~mask;
            alloc_maps[c] |= mask;
            rsp.ok = 1'b1;
          end
        end
      end
      OP_FREE_ALLOC: begin
        if (slot_ok && (alloc_maps[c] & mask) != '0 && (free_maps[c] & mask) == '0) begin
          alloc_maps[c] &= ~mask;
          free_maps[c] |= mask;
          rsp.ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (cls_ok) begin
      rsp.free_map = free_maps[c];
      rsp.alloc_map = alloc_maps[c];
    end
    rsp.touched = touched_classes;
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [MapWidth-1:0] got,
                                 input logic [MapWidth-1:0] want);
    if (err_count < 100) begin
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    end
    err_count++;
  endtask

  task automatic push_req(input logic [1:0] op, input int cls, input int slot);
    alloc_req_t rq;
    rq.op = op;
    rq.cls = ClassIdW'(cls);
    rq.slot = SlotW'(slot);
    pending_reqs.push_back(rq);
    outstanding++;
  endtask

  task automatic write_slots(input int idx, input int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CfgAddrW'(idx);
    cfg_wdata_i <= CountW'(val);
    if (idx < ClassCount) begin
      slot_counts[idx] = CountW'(val);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  // request driver: bursts with random gaps when enabled
  int         burst_left;
  int         gap_left;
  alloc_req_t drv_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(allocate_step(drv_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          drv_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= InDataW'(drv_req);
          if (gaps_on) begin
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left = $urandom_range(0, 5);
            end
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall pattern per phase, one long hold-off
  int rx_tick = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (hold_req && !hold_done) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RxRandom:  m_axis_tready <= 1'($urandom_range(0, 1));
          RxPattern: m_axis_tready <= (rx_tick % 5) < 3;
          RxSparse:  m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    alloc_rsp_t got;
    alloc_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = alloc_rsp_t'(m_axis_tdata[$bits(alloc_rsp_t)-1:0]);
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected transfer, free_map", got.free_map, '0);
      end else begin
        want = expected_rsps.pop_front();
        outstanding--;
        if (got.ok !== want.ok) begin
          report_mismatch("ok", MapWidth'(got.ok), MapWidth'(want.ok));
        end
        if (got.taken !== want.taken) begin
          report_mismatch("taken_slot", MapWidth'(got.taken), MapWidth'(want.taken));
        end
        if (got.free_map !== want.free_map) begin
          report_mismatch("free_map", got.free_map, want.free_map);
        end
        if (got.alloc_map !== want.alloc_map) begin
          report_mismatch("alloc_map", got.alloc_map, want.alloc_map);
        end
        if (got.touched !== want.touched) begin
          report_mismatch("touched_mask", MapWidth'(got.touched), MapWidth'(want.touched));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("per_class_bitmap_slot_allocator verification failed");
      $finish;
    end
  end

  initial begin
    int         val;
    int         hi;
    int         pick;
    int         top;
    alloc_req_t rq;
    for (int k = 0; k < ClassCount; k++) begin
      free_maps[k] = '0;
      alloc_maps[k] = '0;
      slot_counts[k] = CountW'(SlotsMax);
    end
    touched_classes = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    rx_mode <= RxPattern;

    @(negedge clk_i);
    push_req(OP_TAKE, 0, 0);          // nothing free yet
    push_req(OP_PUT, 0, 0);
    push_req(OP_PUT, 0, 63);
    push_req(OP_PUT, 0, 0);           // already free
    push_req(OP_PUT, 7, 63);
    push_req(OP_PUT, 8, 5);           // class out of range
    push_req(OP_TAKE, 15, 0);
    push_req(OP_TAKE, 0, 0);
    push_req(OP_TAKE, 0, 0);
    push_req(OP_TAKE, 0, 0);          // empty again
    push_req(OP_PUT, 0, 63);          // slot is allocated
    push_req(OP_FREE_ALLOC, 0, 0);
    push_req(OP_FREE_ALLOC, 0, 0);    // already free
    push_req(OP_FREE_ALLOC, 0, 5);    // never allocated
    push_req(OpUndefined, 0, 63);     // rejected but maps still reported
    push_req(OpUndefined, 15, 63);
    push_req(OP_FREE_ALLOC, 12, 1);
    push_req(OP_PUT, 5, 40);
    drain();

    write_slots(1, 0);
    write_slots(2, 1);
    write_slots(3, 127);
    write_slots(4, SlotsMax + 1);
    write_slots(5, 10);
    write_slots(8, 127);              // ignored index
    write_slots(15, 0);

    @(negedge clk_i);
    push_req(OP_PUT, 1, 0);           // class with no slots
    push_req(OP_PUT, 2, 0);
    push_req(OP_PUT, 2, 1);
    push_req(OP_PUT, 3, 63);
    push_req(OP_PUT, 4, 63);
    push_req(OP_TAKE, 5, 0);          // slot 40 claimed past the lowered count
    push_req(OP_FREE_ALLOC, 5, 40);   // now beyond the count
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      for (int k = 0; k < ClassCount; k++) begin
        if (ph == 0) begin
          val = SlotsMax;
        end else begin
          case ($urandom_range(0, 9))
            0:       val = 0;
            1:       val = SlotsMax;
            2:       val = $urandom_range(SlotsMax + 1, 127);
            3:       val = 1;
            default: val = $urandom_range(2, 10);
          endcase
        end
        write_slots(k, val);
      end
      write_slots($urandom_range(ClassCount, 15), $urandom_range(0, 127));
      hi = $urandom_range(0, 1);
      gaps_on <= (ph % 3) != 0;
      rx_mode <= ph % 4;
      // sender keeps offering while the receiver holds off
      hold_req <= (ph == 3);

      @(negedge clk_i);
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) rq.op = OP_PUT;
        else if (pick < 68) rq.op = OP_TAKE;
        else if (pick < 95) rq.op = OP_FREE_ALLOC;
        else rq.op = OpUndefined;
        if ($urandom_range(0, 9) == 0) begin
          rq.cls = ClassIdW'($urandom_range(ClassCount, 15));
        end else begin
          rq.cls = ClassIdW'($urandom_range(0, ClassCount - 1));
        end
        top = (rq.cls < ClassCount) ? int'(slot_counts[rq.cls[ClassIdxW-1:0]]) : SlotsMax;
        // keep slots in a narrow window so puts, takes and frees collide
        if ($urandom_range(0, 99) < 15) begin
          rq.slot = SlotW'($urandom);
        end else if (hi != 0 && top >= SlotsMax) begin
          rq.slot = SlotW'($urandom_range(SlotsMax - 10, SlotsMax - 1));
        end else begin
          rq.slot = SlotW'($urandom_range(0, (top < 9) ? top : 9));
        end
        push_req(rq.op, int'(rq.cls), int'(rq.slot));
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("per_class_bitmap_slot_allocator verification clean");
    end else begin
      $display("per_class_bitmap_slot_allocator verification failed");
    end
    $finish;
  end

endmodule

/* per_class_bitmap_slot_allocator.f */
rtl/pcbsa_pkg.sv
rtl/pcbsa_ctrl.sv
rtl/pcbsa_datapath.sv
rtl/per_class_bitmap_slot_allocator.sv
rtl/pcbsa_checker.sv
tb/tb_per_class_bitmap_slot_allocator.sv
